// File: design/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg
// Types and constants shared by the triangle block rasterizer modules.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int PIX_BITS  = 13;
    localparam int CLIP_BITS = 14;
    localparam int VERT_BITS = 18;
    localparam int BLK       = 8;
    localparam int BLK_LOG   = 3;
    localparam int SUBPIX    = 4;
    localparam int EDGE_W    = VERT_BITS + 1;
    localparam int PROD_W    = 37;
    localparam int DIFF_W    = 38;
    localparam int CONST_W   = 38;
    localparam int BASE_W    = 40;
    localparam int OFS_W     = 22;
    localparam int EVAL_W    = 41;
    localparam int PXC_W     = 16;
    localparam int IN_W      = 136;
    localparam int OUT_W     = 120;

    localparam logic [CLIP_BITS-1:0] CLIP_MAX = CLIP_BITS'(1 << PIX_BITS);
    localparam logic signed [VERT_BITS:0] SUBPIX_ROUND = 19'sd15;

    typedef enum logic {
        REQ_SETUP = 1'b0,
        REQ_BLOCK = 1'b1
    } t_req;

    typedef enum logic {
        CFG_CLIP_RIGHT  = 1'b0,
        CFG_CLIP_BOTTOM = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CLIP_BITS-1:0] right;
        logic [CLIP_BITS-1:0] bottom;
    } t_clip;

    typedef struct packed {
        logic [PIX_BITS-1:0] min_x;
        logic [PIX_BITS-1:0] min_y;
        logic [PIX_BITS-1:0] max_x;
        logic [PIX_BITS-1:0] max_y;
        logic                empty;
    } t_box;

    typedef struct packed {
        t_req                          kind;
        logic [2:0][VERT_BITS-1:0]     vx;
        logic [2:0][VERT_BITS-1:0]     vy;
        logic [PIX_BITS-1:0]           blk_x;
        logic [PIX_BITS-1:0]           blk_y;
        t_box                          box;
    } t_qentry;

endpackage

// File: design/trb_front.sv
// ----------------------------------------------------------------------------
// trb_front
// Decodes an input transaction and computes the clipped bounding box of a
// triangle setup before the item is queued.
// ----------------------------------------------------------------------------
module trb_front
    import trb_pkg::*;
(
    input  logic            i_req_type,
    input  logic [IN_W-1:0] i_data,
    input  t_clip           i_clip,
    output t_qentry         o_entry
);

    logic signed [VERT_BITS-1:0] vx [3];
    logic signed [VERT_BITS-1:0] vy [3];
    logic signed [VERT_BITS-1:0] mnx, mxx, mny, mxy;
    logic signed [PXC_W-1:0]     minx, maxx, miny, maxy, limx, limy;
    logic signed [PXC_W-1:0]     cmnx, cmxx, cmny, cmxy;
    logic                        empty;

    function automatic logic signed [PXC_W-1:0] px_ceil(input logic signed [VERT_BITS-1:0] v);
        logic signed [VERT_BITS:0] t;
        t = (VERT_BITS+1)'(v) + SUBPIX_ROUND;
        return PXC_W'(t >>> SUBPIX);
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx[k] = $signed(i_data[36*k +: VERT_BITS]);
            vy[k] = $signed(i_data[36*k + VERT_BITS +: VERT_BITS]);
        end
        mnx = (vx[0] < vx[1]) ? vx[0] : vx[1];
        mnx = (mnx < vx[2]) ? mnx : vx[2];
        mxx = (vx[0] > vx[1]) ? vx[0] : vx[1];
        mxx = (mxx > vx[2]) ? mxx : vx[2];
        mny = (vy[0] < vy[1]) ? vy[0] : vy[1];
        mny = (mny < vy[2]) ? mny : vy[2];
        mxy = (vy[0] > vy[1]) ? vy[0] : vy[1];
        mxy = (mxy > vy[2]) ? mxy : vy[2];
        cmnx = px_ceil(mnx);
        cmxx = px_ceil(mxx);
        cmny = px_ceil(mny);
        cmxy = px_ceil(mxy);
        limx = $signed(PXC_W'(i_clip.right)) - 16'sd1;
        limy = $signed(PXC_W'(i_clip.bottom)) - 16'sd1;
        minx = (cmnx < 16'sd0) ? 16'sd0 : cmnx;
        miny = (cmny < 16'sd0) ? 16'sd0 : cmny;
        maxx = (cmxx > limx) ? limx : cmxx;
        maxy = (cmxy > limy) ? limy : cmxy;
        empty = (minx >= maxx) || (miny >= maxy);

        o_entry.kind  = t_req'(i_req_type);
        for (int k = 0; k < 3; k++) begin
            o_entry.vx[k] = vx[k];
            o_entry.vy[k] = vy[k];
        end
        o_entry.blk_x = i_data[108 +: PIX_BITS];
        o_entry.blk_y = i_data[121 +: PIX_BITS];
        o_entry.box.empty = empty;
        if (empty) begin
            o_entry.box.min_x = '0;
            o_entry.box.min_y = '0;
            o_entry.box.max_x = '0;
            o_entry.box.max_y = '0;
        end else begin
            o_entry.box.min_x = {minx[PIX_BITS-1:BLK_LOG], {BLK_LOG{1'b0}}};
            o_entry.box.min_y = {miny[PIX_BITS-1:BLK_LOG], {BLK_LOG{1'b0}}};
            o_entry.box.max_x = maxx[PIX_BITS-1:0];
            o_entry.box.max_y = maxy[PIX_BITS-1:0];
        end
    end

endmodule

// File: design/trb_queue.sv
// ----------------------------------------------------------------------------
// trb_queue
// Two-entry queue between the front and the back of the rasterizer.
// ----------------------------------------------------------------------------
module trb_queue
    import trb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_qentry i_entry,
    output logic    o_valid,
    input  logic    i_pop,
    output t_qentry o_entry
);

    t_qentry    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_entry;
    end

endmodule

// File: design/trb_back.sv
// ----------------------------------------------------------------------------
// trb_back
// Edge setup and 8x8 block evaluation pipeline with the output register.
// ----------------------------------------------------------------------------
module trb_back
    import trb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_qentry          i_entry,
    input  t_clip            i_clip,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data
);

    logic signed [EDGE_W-1:0]  r_edge_dx [3];
    logic signed [EDGE_W-1:0]  r_edge_dy [3];
    logic signed [CONST_W-1:0] r_edge_const [3];
    logic                      r_tri_loaded;

    logic                      r_s1_valid, r_s2_valid, r_out_valid;
    t_req                      r_s1_kind, r_s2_kind;
    t_box                      r_s1_box, r_s2_box;
    logic [PIX_BITS-1:0]       r_s1_x, r_s1_y, r_s2_x, r_s2_y;
    logic signed [EDGE_W-1:0]  r_s1_dx [3];
    logic signed [EDGE_W-1:0]  r_s1_dy [3];
    logic signed [PROD_W-1:0]  r_s1_pa [3];
    logic signed [PROD_W-1:0]  r_s1_pb [3];
    logic                      r_s1_bias [3];
    logic signed [BASE_W-1:0]  r_s2_base [3];
    logic signed [OFS_W-1:0]   r_s2_row [3][BLK];
    logic signed [OFS_W-1:0]   r_s2_col [3][BLK];
    logic                      r_s2_loaded;

    t_box                      r_box;
    logic [63:0]               r_mask;
    logic                      r_rej, r_full;

    logic                      en, pop;
    logic signed [VERT_BITS-1:0] vx [3];
    logic signed [VERT_BITS-1:0] vy [3];
    logic signed [EDGE_W-1:0]  sdx [3];
    logic signed [EDGE_W-1:0]  sdy [3];
    logic signed [EDGE_W-1:0]  ma [3];
    logic signed [VERT_BITS-1:0] mb [3];
    logic signed [EDGE_W-1:0]  mc [3];
    logic signed [VERT_BITS-1:0] md [3];
    logic signed [DIFF_W-1:0]  d [3];
    logic signed [EVAL_W-1:0]  e;
    logic [63:0]               ins [3];
    logic [63:0]               vis;
    logic [3:0]                cor [3];
    logic [CLIP_BITS-1:0]      px, py;
    logic                      clipneed, rej, full;
    logic [63:0]               mask;

    assign en      = !r_out_valid || i_ready;
    assign pop     = en && i_q_valid;
    assign o_q_pop = en;
    assign o_valid = r_out_valid;
    assign o_data  = {1'b0, r_full, r_rej, r_mask, r_box.empty, r_box.max_y, r_box.max_x,
                      r_box.min_y, r_box.min_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx[k] = $signed(i_entry.vx[k]);
            vy[k] = $signed(i_entry.vy[k]);
        end
        for (int k = 0; k < 3; k++) begin
            sdx[k] = EDGE_W'(vx[k]) - EDGE_W'(vx[(k + 1) % 3]);
            sdy[k] = EDGE_W'(vy[k]) - EDGE_W'(vy[(k + 1) % 3]);
            if (i_entry.kind == REQ_BLOCK) begin
                ma[k] = r_edge_dx[k];
                mb[k] = $signed(VERT_BITS'(i_entry.blk_y));
                mc[k] = r_edge_dy[k];
                md[k] = $signed(VERT_BITS'(i_entry.blk_x));
            end else begin
                ma[k] = EDGE_W'(vx[(k + 1) % 3]);
                mb[k] = vy[k];
                mc[k] = EDGE_W'(vx[k]);
                md[k] = vy[(k + 1) % 3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tri_loaded <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_edge_dx[k]    <= '0;
                r_edge_dy[k]    <= '0;
                r_edge_const[k] <= '0;
            end
        end else if (en) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (pop && i_entry.kind == REQ_SETUP) begin
                for (int k = 0; k < 3; k++) begin
                    r_edge_dx[k] <= sdx[k];
                    r_edge_dy[k] <= sdy[k];
                end
            end
            if (r_s1_valid && r_s1_kind == REQ_SETUP) begin
                r_tri_loaded <= !r_s1_box.empty;
                for (int k = 0; k < 3; k++) begin
                    r_edge_const[k] <= CONST_W'(d[k]) + $signed({{(CONST_W-1){1'b0}},
                                                                   r_s1_bias[k]});
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k] = DIFF_W'(r_s1_pa[k]) - DIFF_W'(r_s1_pb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= i_entry.kind;
            r_s1_box  <= i_entry.box;
            r_s1_x    <= i_entry.blk_x;
            r_s1_y    <= i_entry.blk_y;
            for (int k = 0; k < 3; k++) begin
                r_s1_dx[k]   <= r_edge_dx[k];
                r_s1_dy[k]   <= r_edge_dy[k];
                r_s1_pa[k]   <= ma[k] * mb[k];
                r_s1_pb[k]   <= mc[k] * md[k];
                r_s1_bias[k] <= (sdy[k] < 0) || (sdy[k] == 0 && sdx[k] > 0);
            end
            r_s2_kind   <= r_s1_kind;
            r_s2_box    <= r_s1_box;
            r_s2_x      <= r_s1_x;
            r_s2_y      <= r_s1_y;
            r_s2_loaded <= r_tri_loaded;
            for (int k = 0; k < 3; k++) begin
                r_s2_base[k] <= BASE_W'(r_edge_const[k]) + (BASE_W'(d[k]) <<< SUBPIX);
                for (int j = 0; j < BLK; j++) begin
                    r_s2_row[k][j] <= OFS_W'(r_s1_dx[k]) * OFS_W'(j);
                    r_s2_col[k][j] <= OFS_W'(r_s1_dy[k]) * OFS_W'(j);
                end
            end
            if (r_s2_kind == REQ_SETUP) begin
                r_box  <= r_s2_box;
                r_mask <= '0;
                r_rej  <= 1'b0;
                r_full <= 1'b0;
            end else begin
                r_box  <= '0;
                r_mask <= mask;
                r_rej  <= rej;
                r_full <= full;
            end
        end
    end

    always_comb begin
        e = '0;
        px = '0;
        py = '0;
        for (int k = 0; k < 3; k++) begin
            for (int iy = 0; iy < BLK; iy++) begin
                for (int ix = 0; ix < BLK; ix++) begin
                    e = EVAL_W'(r_s2_base[k]) + (EVAL_W'((OFS_W+1)'(r_s2_row[k][iy])
                        - (OFS_W+1)'(r_s2_col[k][ix])) <<< SUBPIX);
                    ins[k][iy*BLK + ix] = (e > 0);
                end
            end
            cor[k] = {ins[k][63], ins[k][56], ins[k][7], ins[k][0]};
        end
        for (int iy = 0; iy < BLK; iy++) begin
            for (int ix = 0; ix < BLK; ix++) begin
                px = CLIP_BITS'(r_s2_x) + CLIP_BITS'(ix);
                py = CLIP_BITS'(r_s2_y) + CLIP_BITS'(iy);
                vis[iy*BLK + ix] = (px < i_clip.right) && (py < i_clip.bottom);
            end
        end
        clipneed = (CLIP_BITS'(r_s2_x) + CLIP_BITS'(BLK) > i_clip.right)
                || (CLIP_BITS'(r_s2_y) + CLIP_BITS'(BLK) > i_clip.bottom);
        rej  = !r_s2_loaded || (cor[0] == 4'h0) || (cor[1] == 4'h0) || (cor[2] == 4'h0);
        full = !rej && (cor[0] == 4'hF) && (cor[1] == 4'hF) && (cor[2] == 4'hF) && !clipneed;
        if (rej) begin
            mask = '0;
        end else if (full) begin
            mask = '1;
        end else begin
            mask = vis & ins[0] & ins[1] & ins[2];
        end
    end

endmodule

// File: design/triangle_block_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_block_rasterizer
// Half-space triangle rasterizer: triangle setup and 8x8 block coverage.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                        Content
// s_axis    in         i_s_tvalid/tdata/tuser, o_s_tready  setup or block request
// m_axis    out        o_m_tvalid/tdata, i_m_tready   box or block coverage result
// cfg       in         i_cfg_we/addr/wdata            clip_right, clip_bottom
//
// One item is accepted per cycle while the queue has a free entry. Each
// accepted item waits in the queue, then passes the multiplier stage and the
// edge base stage; the 192-evaluation stage then loads the output register.
// The multiplier stage sets the pipeline depth.
// Reset is synchronous; the clip registers come up at 8192.
// A stalled output freezes the pipeline; the queue fills up to its two entries.
// ----------------------------------------------------------------------------
module triangle_block_rasterizer
    import trb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [17:0] vert1_x, [35:18] vert1_y, [53:36] vert2_x, [71:54] vert2_y,
    // [89:72] vert3_x, [107:90] vert3_y, [120:108] block_x, [133:121] block_y
    input  logic [IN_W-1:0]      i_s_tdata,
    // [0] req_type
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [12:0] box_min_x, [25:13] box_min_y, [38:26] box_max_x, [51:39] box_max_y,
    // [52] tri_empty, [116:53] cover_mask, [117] block_rejected, [118] block_full
    output logic [OUT_W-1:0]     o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [CLIP_BITS-1:0] i_cfg_wdata
);

    t_clip                r_clip;
    t_qentry              front_entry, q_entry;
    logic                 q_valid, q_pop;
    logic [CLIP_BITS-1:0] cfg_val;

    assign cfg_val = (i_cfg_wdata > CLIP_MAX) ? CLIP_MAX : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.right  <= CLIP_MAX;
            r_clip.bottom <= CLIP_MAX;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CLIP_RIGHT:  r_clip.right  <= cfg_val;
                CFG_CLIP_BOTTOM: r_clip.bottom <= cfg_val;
                default:         r_clip        <= r_clip;
            endcase
        end
    end

    trb_front u_front (
        .i_req_type (i_s_tuser),
        .i_data     (i_s_tdata),
        .i_clip     (r_clip),
        .o_entry    (front_entry)
    );

    trb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_entry (front_entry),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    trb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_entry   (q_entry),
        .i_clip    (r_clip),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the triangle block rasterizer.
// Triangle setup and 8x8 block requests go in on the input stream. Each
// accepted request is run through an in-house model of the half-space edge
// math; its prediction, or a given directed result, is queued. Every result
// transaction is compared field by field with the oldest queued entry. A
// short list of directed requests comes first, then random triangles and
// blocks under several clip settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_top
    import trb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 900;
    localparam int  N_PHASES   = 8;
    localparam longint CYC_CAP = 400000;

    typedef struct {
        t_req                   kind;
        logic signed [VERT_BITS-1:0] vx [3];
        logic signed [VERT_BITS-1:0] vy [3];
        logic [PIX_BITS-1:0]    bx;
        logic [PIX_BITS-1:0]    by;
    } t_item;

    typedef struct {
        logic [PIX_BITS-1:0] min_x;
        logic [PIX_BITS-1:0] min_y;
        logic [PIX_BITS-1:0] max_x;
        logic [PIX_BITS-1:0] max_y;
        logic                empty;
        logic [63:0]         mask;
        logic                rejected;
        logic                full;
    } t_result;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 i_cfg_we;
    logic                 i_cfg_addr;
    logic [CLIP_BITS-1:0] i_cfg_wdata;

    triangle_block_rasterizer u_dut (.*);

    // Model state.
    longint  clip_r, clip_b;
    longint  e_dx [3];
    longint  e_dy [3];
    longint  e_c  [3];
    bit      tri_ok;
    t_result last_box;

    t_result pending_results [$];
    t_row    directed_rows [$];
    int      n_errors;
    longint  n_cycles;
    int      idle_pct;
    int      stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYC_CAP) begin
            $display("** triangle_block_rasterizer: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic longint pix_ceil(longint v);
        return (v + 15) >>> SUBPIX;
    endfunction

    function automatic longint edge_at(int k, longint px, longint py);
        return e_c[k] + e_dx[k] * (py * 16) - e_dy[k] * (px * 16);
    endfunction

    function automatic t_result rasterize(t_item it);
        t_result r;
        longint  x [3];
        longint  y [3];
        longint  mnx, mxx, mny, mxy, px, py, dx, dy, c;
        bit [3:0] corner [3];
        bit      clipneeded;
        int      n;
        r = '{default: '0};
        if (it.kind == REQ_SETUP) begin
            for (int k = 0; k < 3; k++) begin
                x[k] = it.vx[k];
                y[k] = it.vy[k];
            end
            mnx = x[0]; mxx = x[0]; mny = y[0]; mxy = y[0];
            for (int k = 1; k < 3; k++) begin
                if (x[k] < mnx) mnx = x[k];
                if (x[k] > mxx) mxx = x[k];
                if (y[k] < mny) mny = y[k];
                if (y[k] > mxy) mxy = y[k];
            end
            mnx = pix_ceil(mnx); mxx = pix_ceil(mxx);
            mny = pix_ceil(mny); mxy = pix_ceil(mxy);
            if (mnx < 0) mnx = 0;
            if (mny < 0) mny = 0;
            if (mxx > clip_r - 1) mxx = clip_r - 1;
            if (mxy > clip_b - 1) mxy = clip_b - 1;
            if (mnx >= mxx || mny >= mxy) begin
                tri_ok = 1'b0;
                r.empty = 1'b1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    n = (k + 1) % 3;
                    dx = x[k] - x[n];
                    dy = y[k] - y[n];
                    c = dy * x[k] - dx * y[k];
                    if (dy < 0 || (dy == 0 && dx > 0)) c = c + 1;
                    e_dx[k] = dx;
                    e_dy[k] = dy;
                    e_c[k] = c;
                end
                tri_ok = 1'b1;
                r.min_x = PIX_BITS'(mnx & ~longint'(BLK - 1));
                r.min_y = PIX_BITS'(mny & ~longint'(BLK - 1));
                r.max_x = PIX_BITS'(mxx);
                r.max_y = PIX_BITS'(mxy);
                last_box = r;
            end
        end else if (!tri_ok) begin
            r.rejected = 1'b1;
        end else begin
            px = it.bx;
            py = it.by;
            for (int k = 0; k < 3; k++) begin
                corner[k][0] = edge_at(k, px, py) > 0;
                corner[k][1] = edge_at(k, px + BLK - 1, py) > 0;
                corner[k][2] = edge_at(k, px, py + BLK - 1) > 0;
                corner[k][3] = edge_at(k, px + BLK - 1, py + BLK - 1) > 0;
            end
            if (corner[0] == 0 || corner[1] == 0 || corner[2] == 0) begin
                r.rejected = 1'b1;
            end else begin
                clipneeded = (px + BLK > clip_r) || (py + BLK > clip_b);
                r.full = corner[0] == 4'hF && corner[1] == 4'hF && corner[2] == 4'hF
                         && !clipneeded;
                if (r.full) begin
                    r.mask = '1;
                end else begin
                    for (int iy = 0; iy < BLK; iy++) begin
                        for (int ix = 0; ix < BLK; ix++) begin
                            if (px + ix < clip_r && py + iy < clip_b
                                && edge_at(0, px + ix, py + iy) > 0
                                && edge_at(1, px + ix, py + iy) > 0
                                && edge_at(2, px + ix, py + iy) > 0)
                                r.mask[iy * BLK + ix] = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result transaction, expected none, got %h",
                         $time, o_m_tdata);
            end else begin
                e = pending_results.pop_front();
                check_field("box_min_x", e.min_x, o_m_tdata[12:0]);
                check_field("box_min_y", e.min_y, o_m_tdata[25:13]);
                check_field("box_max_x", e.max_x, o_m_tdata[38:26]);
                check_field("box_max_y", e.max_y, o_m_tdata[51:39]);
                check_field("tri_empty", e.empty, o_m_tdata[52]);
                check_field("cover_mask", e.mask, o_m_tdata[116:53]);
                check_field("block_rejected", e.rejected, o_m_tdata[117]);
                check_field("block_full", e.full, o_m_tdata[118]);
            end
        end
    end

    task automatic send_item(t_item it, bit typed, t_result typed_res);
        t_result r;
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.kind;
        i_s_tdata  <= {2'b00, it.by, it.bx, it.vy[2], it.vx[2], it.vy[1], it.vx[1],
                       it.vy[0], it.vx[0]};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        r = rasterize(it);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_clip(t_cfg_idx idx, logic [CLIP_BITS-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        if (idx == CFG_CLIP_RIGHT) clip_r = (v > CLIP_MAX) ? CLIP_MAX : v;
        else clip_b = (v > CLIP_MAX) ? CLIP_MAX : v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_item make_tri(int x0, int y0, int x1, int y1, int x2, int y2);
        t_item it;
        it.kind = REQ_SETUP;
        it.vx[0] = VERT_BITS'(x0); it.vy[0] = VERT_BITS'(y0);
        it.vx[1] = VERT_BITS'(x1); it.vy[1] = VERT_BITS'(y1);
        it.vx[2] = VERT_BITS'(x2); it.vy[2] = VERT_BITS'(y2);
        it.bx = PIX_BITS'($urandom());
        it.by = PIX_BITS'($urandom());
        return it;
    endfunction

    function automatic t_item make_blk(int x, int y);
        t_item it;
        it.kind = REQ_BLOCK;
        for (int k = 0; k < 3; k++) begin
            it.vx[k] = VERT_BITS'($urandom());
            it.vy[k] = VERT_BITS'($urandom());
        end
        it.bx = PIX_BITS'(x);
        it.by = PIX_BITS'(y);
        return it;
    endfunction

    function automatic void add_row(t_item it, bit typed = 1'b0, t_result res = '{default: '0});
        directed_rows.push_back('{item: it, typed: typed, res: res});
    endfunction

    function automatic int clamp_vert(int v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    cx, cy, sz, lim;
        if ($urandom_range(99) < 25) begin
            it = make_tri(0, 0, 0, 0, 0, 0);
            if ($urandom_range(99) < 20) begin
                for (int k = 0; k < 3; k++) begin
                    it.vx[k] = VERT_BITS'($urandom());
                    it.vy[k] = VERT_BITS'($urandom());
                end
            end else begin
                lim = (clip_r < 600) ? int'(clip_r) : 600;
                cx = $urandom_range(0, lim + 16) * 16;
                lim = (clip_b < 600) ? int'(clip_b) : 600;
                cy = $urandom_range(0, lim + 16) * 16;
                sz = ($urandom_range(99) < 15) ? 16000 : $urandom_range(2, 1500);
                for (int k = 0; k < 3; k++) begin
                    it.vx[k] = VERT_BITS'(clamp_vert(cx + $urandom_range(0, 2 * sz) - sz));
                    it.vy[k] = VERT_BITS'(clamp_vert(cy + $urandom_range(0, 2 * sz) - sz));
                end
            end
        end else if (tri_ok && $urandom_range(99) < 85) begin
            it = make_blk($urandom_range(last_box.min_x, last_box.max_x),
                          $urandom_range(last_box.min_y, last_box.max_y));
            if ($urandom_range(99) < 90) begin
                it.bx = it.bx & ~13'd7;
                it.by = it.by & ~13'd7;
            end
        end else begin
            it = make_blk($urandom(), $urandom());
        end
        return it;
    endfunction

    initial begin
        t_result          r_rej, r_empty;
        logic [CLIP_BITS-1:0] clip_set [N_PHASES][2];
        n_errors   = 0;
        n_cycles   = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b1;
        i_cfg_we   = 1'b0;
        i_cfg_addr = 1'b0;
        i_cfg_wdata = '0;
        clip_r = CLIP_MAX;
        clip_b = CLIP_MAX;
        for (int k = 0; k < 3; k++) begin
            e_dx[k] = 0; e_dy[k] = 0; e_c[k] = 0;
        end
        tri_ok = 1'b0;
        last_box = '{default: '0};

        r_rej = '{default: '0};
        r_rej.rejected = 1'b1;
        r_empty = '{default: '0};
        r_empty.empty = 1'b1;

        add_row(make_blk(0, 0), 1'b1, r_rej);
        add_row(make_tri(0, 0, 160, 0, 0, 160));
        add_row(make_blk(0, 0));
        add_row(make_blk(8, 8));
        add_row(make_tri(0, 0, 0, 160, 160, 0));
        add_row(make_blk(0, 0));
        add_row(make_blk(3, 5));
        add_row(make_tri(-1600, -1600, 16000, -1600, -1600, 16000));
        add_row(make_blk(0, 0));
        add_row(make_blk(64, 64));
        add_row(make_tri(-1600, -1600, -1600, 16000, 16000, -1600));
        add_row(make_blk(16, 24));
        add_row(make_tri(131071, 131071, 131071, 131071, 131071, 131071), 1'b1, r_empty);
        add_row(make_blk(8, 8), 1'b1, r_rej);
        add_row(make_tri(-131072, -131072, 131071, -131072, -131072, 131071));
        add_row(make_blk(0, 0));
        add_row(make_blk(8184, 8184));
        add_row(make_blk(8191, 8191));
        add_row(make_blk(4000, 4000));
        add_row(make_tri(-131072, -131072, -131072, -131072, -131072, -131072),
                1'b1, r_empty);
        add_row(make_tri(100, 100, 100, 900, 900, 100));
        add_row(make_blk(8, 8));
        add_row(make_blk(48, 48));

        clip_set[0] = '{14'd8192, 14'd8192};
        clip_set[1] = '{14'd640, 14'd480};
        clip_set[2] = '{14'd1, 14'd1};
        clip_set[3] = '{14'd16383, 14'd16383};
        clip_set[4] = '{14'd17, 14'd9};
        clip_set[5] = '{14'd0, 14'd300};
        clip_set[6] = '{14'd200, 14'd8191};
        clip_set[7] = '{14'd8193, 14'd13};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_clip(CFG_CLIP_RIGHT, clip_set[ph][0]);
            write_clip(CFG_CLIP_BOTTOM, clip_set[ph][1]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int n = 0; n < N_RANDOM / N_PHASES; n++)
                send_item(random_item(), 1'b0, '{default: '0});
            drain();
            idle_pct  = 0;
            stall_pct = 0;
        end

        if (n_errors == 0) begin
            $display("** triangle_block_rasterizer: PASSED **");
        end else begin
            $display("** triangle_block_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/trb_pkg.sv
design/trb_front.sv
design/trb_queue.sv
design/trb_back.sv
design/triangle_block_rasterizer.sv
verif/tb_top.sv
